// ===== src/upd_pkg.sv =====
// ----------------------------------------------------------------------------
// upd_pkg
// Types, character constants and hex helpers for the percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

   localparam int CHAR_BITS   = 16;
   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [CHAR_BITS-1:0] CH_PERCENT   = 16'h0025;
   localparam logic [CHAR_BITS-1:0] CH_PLUS      = 16'h002B;
   localparam logic [CHAR_BITS-1:0] CH_SLASH     = 16'h002F;
   localparam logic [CHAR_BITS-1:0] CH_BACKSLASH = 16'h005C;
   localparam logic [CHAR_BITS-1:0] CH_SPACE     = 16'h0020;

   localparam logic [CSR_IDX_BITS-1:0] CSR_PLUS_AS_SPACE = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FLIP_SLASHES  = 2'd1;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_PCT  = 2'd1,
      MODE_HEX  = 2'd2
   } mode_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] in_char;
      logic                 in_last;
   } req_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] out_char;
      logic                 run_last;
      logic                 stream_last;
   } rsp_type;

   typedef struct packed {
      logic plus_as_space;
      logic flip_slashes;
   } cfg_type;

   typedef struct packed {
      logic [MAX_RESULTS-1:0][CHAR_BITS-1:0] chars;
      logic [1:0]                            count;
      logic                                  last;
   } pkt_type;

   function automatic logic is_hex(input logic [CHAR_BITS-1:0] c);
      return (c inside {[16'h0030:16'h0039], [16'h0041:16'h0046], [16'h0061:16'h0066]});
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [CHAR_BITS-1:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c inside {[16'h0030:16'h0039]}) begin
         v = c[3:0];
      end else if (c inside {[16'h0041:16'h0046], [16'h0061:16'h0066]}) begin
         v = c[3:0] + 4'd9;
      end
      return v;
   endfunction

endpackage

// ===== src/upd_front.sv =====
// ----------------------------------------------------------------------------
// upd_front
// Escape tracker: classifies each accepted character and forms a packet of
// up to three decoded characters.
// ----------------------------------------------------------------------------
module upd_front import upd_pkg::*; #(
   parameter int CHAR_WIDTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    accept,
   input  req_type req,
   output logic    pkt_valid,
   output pkt_type pkt
);

   localparam int KeepBits = (CHAR_WIDTH < CHAR_BITS) ? CHAR_WIDTH : CHAR_BITS;
   localparam logic [CHAR_BITS-1:0] CharMask =
      CHAR_BITS'((64'd1 << KeepBits) - 64'd1);

   mode_type             mode_ff, mode_in;
   logic [CHAR_BITS-1:0] held_ff, held_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         held_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         held_ff <= held_in;
      end
   end

   always_comb begin
      logic [CHAR_BITS-1:0] c;
      logic [1:0]           n;
      logic                 do_idle;

      c = req.in_char & CharMask;
      if (cfg.flip_slashes && c == CH_SLASH) begin
         c = CH_BACKSLASH;
      end

      n         = 2'd0;
      pkt.chars = '0;
      mode_in   = MODE_IDLE;
      held_in   = held_ff;
      do_idle   = 1'b0;

      case (mode_ff)
         MODE_PCT: begin
            if (c == CH_PERCENT) begin
               pkt.chars[n] = CH_PERCENT;
               n = n + 2'd1;
            end else if (is_hex(c)) begin
               held_in = c;
               mode_in = MODE_HEX;
            end else begin
               pkt.chars[n] = CH_PERCENT;
               n = n + 2'd1;
               do_idle = 1'b1;
            end
         end
         MODE_HEX: begin
            if (is_hex(c)) begin
               pkt.chars[n] = {8'd0, hex_nibble(held_ff), hex_nibble(c)};
               n = n + 2'd1;
            end else begin
               pkt.chars[n] = CH_PERCENT;
               n = n + 2'd1;
               pkt.chars[n] = held_ff;
               n = n + 2'd1;
               do_idle = 1'b1;
            end
         end
         default: begin
            do_idle = 1'b1;
         end
      endcase

      if (do_idle) begin
         if (c == CH_PERCENT) begin
            mode_in = MODE_PCT;
         end else if (c == CH_PLUS && cfg.plus_as_space) begin
            pkt.chars[n] = CH_SPACE;
            n = n + 2'd1;
         end else begin
            pkt.chars[n] = c;
            n = n + 2'd1;
         end
      end

      if (req.in_last) begin
         if (mode_in == MODE_PCT) begin
            pkt.chars[n] = CH_PERCENT;
            n = n + 2'd1;
         end else if (mode_in == MODE_HEX) begin
            pkt.chars[n] = CH_PERCENT;
            n = n + 2'd1;
            pkt.chars[n] = held_in;
            n = n + 2'd1;
         end
         mode_in = MODE_IDLE;
      end

      pkt.count = n;
      pkt.last  = req.in_last;
      pkt_valid = accept && (n != 2'd0);
   end

endmodule

// ===== src/upd_queue.sv =====
// ----------------------------------------------------------------------------
// upd_queue
// Short packet queue between the escape tracker and the serializer.
// ----------------------------------------------------------------------------
module upd_queue import upd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  pkt_type push_pkt,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output pkt_type head_pkt
);

   localparam int PtrBits = $clog2(QUEUE_DEPTH);
   localparam int CntBits = $clog2(QUEUE_DEPTH + 1);

   pkt_type              slot_ff [QUEUE_DEPTH];
   logic [PtrBits-1:0]   wr_ff, wr_in;
   logic [PtrBits-1:0]   rd_ff, rd_in;
   logic [CntBits-1:0]   cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_pkt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_comb begin
      wr_in  = push ? PtrBits'((32'(wr_ff) + 32'd1) % QUEUE_DEPTH) : wr_ff;
      rd_in  = pop  ? PtrBits'((32'(rd_ff) + 32'd1) % QUEUE_DEPTH) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + CntBits'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CntBits'(1);
      end
   end

   assign full       = (cnt_ff == CntBits'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_pkt   = slot_ff[rd_ff];

endmodule

// ===== src/upd_back.sv =====
// ----------------------------------------------------------------------------
// upd_back
// Serializer: sends the characters of each packet one at a time through a
// registered result stage.
// ----------------------------------------------------------------------------
module upd_back import upd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  pkt_type head_pkt,
   output logic    head_pop,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp
);

   logic       out_valid_ff, out_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic [1:0] idx_ff, idx_in;
   logic       load;
   logic       at_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      load     = head_valid && (!out_valid_ff || pop);
      at_end   = (idx_ff == head_pkt.count - 2'd1);
      head_pop = load && at_end;

      rsp_in.out_char    = head_pkt.chars[idx_ff];
      rsp_in.run_last    = at_end;
      rsp_in.stream_last = at_end && head_pkt.last;

      idx_in = idx_ff;
      if (load) begin
         idx_in = at_end ? 2'd0 : idx_ff + 2'd1;
      end

      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   assign empty = !out_valid_ff;
   assign rsp   = rsp_ff;

endmodule

// ===== src/url_percent_decoder.sv =====
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming URL percent-escape decoder with slash flipping and plus to space.
// ----------------------------------------------------------------------------
// Characters enter through a queue-style port: one transfer when push is high
// and full is low. Decoded characters leave the same way: the oldest result
// sits on rsp_data while empty is low and moves on a transfer with pop high.
// Each input character gives zero to three results; run_last marks the last
// result of one input and stream_last the last result of a string.
// With nothing waiting, a result passes through the queue slot and then the
// registered result stage before it appears. The escape tracker takes one
// character every cycle while full is low; the serializer sends one result
// per cycle while the receiver pops, and inputs that yield two or three
// results are absorbed by a four-packet queue.
// When the receiver stalls, the queue fills and full rises; nothing is lost.
// The csr channel is always ready; the user is to write registers through it
// only while the block is idle; the block does not enforce it. Reset clears
// the escape state, empties the queue and sets both registers to one.
// ----------------------------------------------------------------------------
module url_percent_decoder import upd_pkg::*; #(
   parameter int CHAR_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  req_type                 req_data,
   output logic                    empty,
   input  logic                    pop,
   output rsp_type                 rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic                    csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    accept;
   logic    q_push;
   pkt_type q_push_pkt;
   logic    q_pop;
   logic    q_head_valid;
   pkt_type q_head_pkt;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{plus_as_space: 1'b1, flip_slashes: 1'b1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PLUS_AS_SPACE: cfg_in.plus_as_space = csr_data;
            CSR_FLIP_SLASHES:  cfg_in.flip_slashes  = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign accept    = push && !full;

   upd_front #(
      .CHAR_WIDTH(CHAR_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .accept   (accept),
      .req      (req_data),
      .pkt_valid(q_push),
      .pkt      (q_push_pkt)
   );

   upd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_pkt  (q_push_pkt),
      .full      (full),
      .pop       (q_pop),
      .head_valid(q_head_valid),
      .head_pkt  (q_head_pkt)
   );

   upd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(q_head_valid),
      .head_pkt  (q_head_pkt),
      .head_pop  (q_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp       (rsp_data)
   );

   // The queue is never written while it is full.
   assert property (@(posedge clock) disable iff (reset) !(q_push && full))
      else $error("packet written into a full queue");

   // A packet always carries at least one character.
   assert property (@(posedge clock) disable iff (reset) q_push |-> (q_push_pkt.count != 2'd0))
      else $error("empty packet written into the queue");

   // The final character of a string always produces a packet.
   assert property (@(posedge clock) disable iff (reset) (accept && req_data.in_last) |-> q_push)
      else $error("end of string produced no result");

   // A packet is only taken from a non-empty queue.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_head_valid)
      else $error("packet taken from an empty queue");

endmodule

// ===== test/url_percent_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// url_percent_decoder_tb
// Self-checking bench for the streaming URL percent-escape decoder.
// ----------------------------------------------------------------------------
// Characters go in through the push/full port and decoded characters are
// popped from the empty/pop port. Each accepted input is decoded by a
// behavioral copy of the escape tracker, and the characters it yields wait in
// a queue until the block returns them. The run covers directed escapes,
// every register setting and long random streams under varied back-pressure.
// ----------------------------------------------------------------------------
module url_percent_decoder_tb;
   import upd_pkg::*;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_HIGH = 2'd3;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    push = 1'b0;
   logic                    full;
   req_type                 req_data = '0;
   logic                    empty;
   logic                    pop = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic                    csr_data = 1'b0;

   logic        plus_cfg = 1'b1;
   logic        flip_cfg = 1'b1;
   mode_type    esc_mode = MODE_IDLE;
   logic [15:0] held_digit = '0;
   logic [15:0] run_chars[$];
   rsp_type     decoded_due[$];
   rsp_type     due_rsp;
   int          mismatch_count = 0;
   int          chars_sent = 0;
   int          req_gap_pct = 0;
   int          rsp_stall_pct = 0;

   url_percent_decoder u_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   always #6 clock = ~clock;

   initial begin
      #2000000;
      $display("url_percent_decoder test failed");
      $finish;
   end

   always @(negedge clock) begin
      pop <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (decoded_due.size() == 0) begin
            $display("%0t: no result due, expected none, actual %h", $time, rsp_data);
            mismatch_count++;
         end else begin
            due_rsp = decoded_due.pop_front();
            if (rsp_data.out_char !== due_rsp.out_char) begin
               $display("%0t: out_char expected %h actual %h", $time,
                        due_rsp.out_char, rsp_data.out_char);
               mismatch_count++;
            end
            if (rsp_data.run_last !== due_rsp.run_last) begin
               $display("%0t: run_last expected %b actual %b", $time,
                        due_rsp.run_last, rsp_data.run_last);
               mismatch_count++;
            end
            if (rsp_data.stream_last !== due_rsp.stream_last) begin
               $display("%0t: stream_last expected %b actual %b", $time,
                        due_rsp.stream_last, rsp_data.stream_last);
               mismatch_count++;
            end
         end
      end
   end

   function automatic int hex_digit_value(input logic [15:0] c);
      if (c >= 16'h0030 && c <= 16'h0039) return int'(c) - 'h30;
      if (c >= 16'h0041 && c <= 16'h0046) return int'(c) - 'h41 + 10;
      if (c >= 16'h0061 && c <= 16'h0066) return int'(c) - 'h61 + 10;
      return -1;
   endfunction

   function automatic void emit(input logic [15:0] c);
      run_chars.push_back(c);
   endfunction

   function automatic void decode_plain(input logic [15:0] c);
      if (c == CH_PERCENT) begin
         esc_mode = MODE_PCT;
      end else if (c == CH_PLUS && plus_cfg) begin
         emit(CH_SPACE);
      end else begin
         emit(c);
      end
   endfunction

   function automatic void decode_predicted(input req_type item);
      logic [15:0] c;
      int          lo;
      int          hi;
      rsp_type     r;
      c = item.in_char;
      run_chars.delete();
      if (flip_cfg && c == CH_SLASH) c = CH_BACKSLASH;
      lo = hex_digit_value(c);
      case (esc_mode)
         MODE_PCT: begin
            if (c == CH_PERCENT) begin
               emit(CH_PERCENT);
               esc_mode = MODE_IDLE;
            end else if (lo >= 0) begin
               held_digit = c;
               esc_mode = MODE_HEX;
            end else begin
               emit(CH_PERCENT);
               esc_mode = MODE_IDLE;
               decode_plain(c);
            end
         end
         MODE_HEX: begin
            if (lo >= 0) begin
               hi = hex_digit_value(held_digit);
               if (hi < 0) hi = 0;
               emit(16'(hi * 16 + lo));
               esc_mode = MODE_IDLE;
            end else begin
               emit(CH_PERCENT);
               emit(held_digit);
               esc_mode = MODE_IDLE;
               decode_plain(c);
            end
         end
         default: begin
            esc_mode = MODE_IDLE;
            decode_plain(c);
         end
      endcase
      if (item.in_last) begin
         if (esc_mode == MODE_PCT) begin
            emit(CH_PERCENT);
         end else if (esc_mode == MODE_HEX) begin
            emit(CH_PERCENT);
            emit(held_digit);
         end
         esc_mode = MODE_IDLE;
      end
      foreach (run_chars[i]) begin
         r.out_char = run_chars[i];
         r.run_last = (i == run_chars.size() - 1);
         r.stream_last = r.run_last && item.in_last;
         decoded_due.push_back(r);
      end
   endfunction

   function automatic logic [15:0] pick_hex_char();
      int v;
      v = $urandom_range(0, 21);
      if (v < 10) return 16'(16'h0030 + v);
      if (v < 16) return 16'(16'h0061 + v - 10);
      return 16'(16'h0041 + v - 16);
   endfunction

   // Characters next to the hex ranges, the special characters, and look-alikes
   // whose low byte matches but whose upper byte does not.
   function automatic logic [15:0] pick_odd_char();
      case ($urandom_range(0, 11))
         0: return CH_PLUS;
         1: return CH_SLASH;
         2: return CH_BACKSLASH;
         3: return CH_PERCENT;
         4: return 16'h003A;
         5: return 16'h0040;
         6: return 16'h0047;
         7: return 16'h0060;
         8: return 16'h0067;
         9: return 16'h0141;
         10: return 16'hFF25;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic random_last();
      return ($urandom_range(0, 11) == 0);
   endfunction

   task automatic send_char(input logic [15:0] ch, input logic last);
      req_type item;
      item.in_char = ch;
      item.in_last = last;
      push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (full) @(posedge clock);
      decode_predicted(item);
      chars_sent++;
      @(negedge clock);
      if ($urandom_range(0, 99) < req_gap_pct) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   task automatic send_text(input string s, input logic last_at_end);
      for (int i = 0; i < s.len(); i++) begin
         send_char({8'h00, s[i]}, last_at_end && (i == s.len() - 1));
      end
   endtask

   task automatic wait_idle();
      push <= 1'b0;
      while (decoded_due.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input logic val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_PLUS_AS_SPACE) begin
         plus_cfg = val;
      end else if (idx == CSR_FLIP_SLASHES) begin
         flip_cfg = val;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic test_directed_escapes();
      req_gap_pct = 11;
      rsp_stall_pct = 55;
      send_text("%4a", 1'b0);
      send_text("%%", 1'b0);
      send_text("+", 1'b0);
      send_text("/", 1'b0);
      send_text("%2F", 1'b0);
      send_text("%/", 1'b0);
      send_text("%4g", 1'b0);
      send_text("%F%7E", 1'b0);
      send_text("%", 1'b1);
      send_text("%a", 1'b1);
      send_char(16'hFFFF, 1'b0);
      send_char(16'h0000, 1'b1);
   endtask

   task automatic test_config_registers();
      wait_idle();
      write_reg(CSR_PLUS_AS_SPACE, 1'b0);
      write_reg(CSR_FLIP_SLASHES, 1'b0);
      send_text("+/%2B", 1'b1);
      wait_idle();
      write_reg(CSR_SPARE_LOW, 1'b1);
      write_reg(CSR_SPARE_HIGH, 1'b1);
      send_text("+/", 1'b1);
      wait_idle();
      write_reg(CSR_PLUS_AS_SPACE, 1'b1);
      send_text("a+b/", 1'b1);
      wait_idle();
      write_reg(CSR_PLUS_AS_SPACE, 1'b0);
      write_reg(CSR_FLIP_SLASHES, 1'b1);
      send_text("+/%2f", 1'b1);
   endtask

   task automatic send_random_piece();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            send_char(CH_PERCENT, random_last());
            send_char(pick_hex_char(), random_last());
            send_char(pick_hex_char(), random_last());
         end
         4: begin
            send_char(CH_PERCENT, random_last());
            send_char(CH_PERCENT, random_last());
         end
         5: send_char(pick_odd_char(), random_last());
         6: send_char(16'($urandom_range(0, 65535)), random_last());
         7: begin
            send_char(CH_PERCENT, random_last());
            if ($urandom_range(0, 1)) send_char(pick_hex_char(), random_last());
            send_char(pick_odd_char(), random_last());
         end
         8: send_char(16'($urandom_range(16'h0020, 16'h007E)), random_last());
         default: begin
            send_char(CH_PERCENT, 1'b0);
            send_char(pick_hex_char(), 1'b1);
         end
      endcase
   endtask

   task automatic test_random_stream(input int count, input int gap_pct,
                                     input int stall_pct, input logic plus_val,
                                     input logic flip_val);
      int stop_at;
      int pause_at;
      wait_idle();
      write_reg(CSR_PLUS_AS_SPACE, plus_val);
      write_reg(CSR_FLIP_SLASHES, flip_val);
      req_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      stop_at = chars_sent + count;
      pause_at = chars_sent + count / 2;
      while (chars_sent < stop_at) begin
         send_random_piece();
         // Hold the sender once per stream until every decoded character is out.
         if (pause_at != 0 && chars_sent >= pause_at) begin
            pause_at = 0;
            wait_idle();
         end
      end
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      test_directed_escapes();
      test_config_registers();
      test_random_stream(115, 11, 55, 1'b1, 1'b1);
      test_random_stream(115, 55, 11, 1'b0, 1'b0);
      test_random_stream(115, 0, 0, 1'b1, 1'b0);
      wait_idle();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("url_percent_decoder test passed");
      end else begin
         $display("url_percent_decoder test failed");
      end
      $finish;
   end

endmodule
